// ----- hdl/sadf_pkg.sv -----
package sadf_pkg;

  // default sizing
  localparam int DEF_MAX_LIVE     = 16;
  localparam int DEF_MAX_PENDING  = 16;
  localparam int DEF_HEADER_BYTES = 4;

  // fixed field widths
  localparam int ADDR_W  = 32;
  localparam int USED_W  = 25;
  localparam int SIZE_W  = 24;
  localparam int ALIGN_W = 8;
  localparam int ADJ_W   = 9;
  localparam int LIVEO_W = 5;
  localparam int TOTAL_W = 26;

  // configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic [CFG_AW-1:0] REG_BASE_ADDR = 3'd0;
  localparam logic [CFG_AW-1:0] REG_POOL_ADDR = 3'd4;
  localparam logic [USED_W-1:0] POOL_RESET    = 25'd65536;

  typedef enum logic [1:0] {
    KIND_ALLOC = 2'd0,
    KIND_FREE  = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_POOL_FULL = 2'd1,
    ST_BOOK_FULL = 2'd2,
    ST_INVALID   = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DECODE,
    S_ALIGN,
    S_COMMIT,
    S_LTEST,
    S_LRD,
    S_LCMP,
    S_POP,
    S_CHK,
    S_CHKDATA,
    S_PTEST,
    S_PRD,
    S_PCMP,
    S_DROPRD,
    S_DROPWR,
    S_PUSH,
    S_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic    load_in;
    logic    alloc_prep;
    logic    alloc_commit;
    logic    lscan_init;
    logic    live_rd_idx;
    logic    live_rd_top;
    logic    lidx_dec;
    logic    pop;
    logic    tgt_in;
    logic    tgt_live;
    logic    pend_rd_idx;
    logic    pend_rd_last;
    logic    pidx_inc;
    logic    drop_wr;
    logic    push;
    logic    clear;
    logic    set_st;
    status_t st;
    logic    emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    kind_t kind;
    logic  faddr_zero;
    logic  lidx_zero;
    logic  live_hit;
    logic  hit_top;
    logic  lcount_zero;
    logic  pidx_end;
    logic  pend_hit;
    logic  pend_full;
    logic  out_free;
  } stat_t;

endpackage

// ----- hdl/stack_allocator_deferred_free.sv -----
// Stack allocator with deferred frees over a bump-pointer pool. Each input
// beat is one request (tuser: 0 allocate, 1 free, 2 clear) and yields exactly
// one result beat with the aligned block address, a status code (0 ok,
// 1 pool exhausted, 2 bookkeeping full, 3 invalid request), the bytes in use
// and the live block count afterward. An allocate reserves the header room
// below the aligned address. A free walks the live list newest first, and
// pops the block if it is the top one; each deferred block that then
// surfaces is found by a scan of the pending list, dropped from it and popped.
// Freeing an older block scans the pending list and appends it. Both lists
// sit in single-port-read memories with registered outputs, and one
// controller steps through them, so only one request is in flight; the result
// register lets the next request be accepted while the previous result waits.
// The user sets the pool base and size through the apb port (base at 0x0, size
// at 0x4) while the block is idle; the block itself does not enforce this.
module stack_allocator_deferred_free
  import sadf_pkg::*;
#(
  parameter int MAX_LIVE     = DEF_MAX_LIVE,
  parameter int MAX_PENDING  = DEF_MAX_PENDING,
  parameter int HEADER_BYTES = DEF_HEADER_BYTES
)(
  input  logic              clk,
  input  logic              rst_n,
  // request channel
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [63:0]       in_tdata,   // request_size[23:0], align_bytes[31:24],
                                        // free_address[63:32]
  input  logic [1:0]        in_tuser,   // kind[1:0]
  // result channel
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [63:0]       out_tdata,  // block_address[31:0], status[33:32],
                                        // used_after[58:34], live_after[63:59]
  // configuration
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  logic [ADDR_W-1:0] base;
  logic [USED_W-1:0] pool;
  cmd_t              cmd;
  stat_t             stat;

  // pool base and size registers
  sadf_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .base_o  (base),
    .pool_o  (pool)
  );

  // sequencer: decode, list scans, pop cascade, result hand-off
  sadf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // counters, list memories, alignment math and result register
  sadf_dp #(
    .MAX_LIVE     (MAX_LIVE),
    .MAX_PENDING  (MAX_PENDING),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .base       (base),
    .pool       (pool),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ----- hdl/sadf_regs.sv -----
module sadf_regs
  import sadf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output logic [ADDR_W-1:0] base_o,
  output logic [USED_W-1:0] pool_o
);

  logic [ADDR_W-1:0] base_r;
  logic [USED_W-1:0] pool_r;
  logic              wr_en;
  logic              sel_pool;

  assign pready   = 1'b1;
  assign wr_en    = psel && penable && pwrite && pready;
  // decode on the word index only
  assign sel_pool = paddr[2] == REG_POOL_ADDR[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
      pool_r <= POOL_RESET;
    end else if (wr_en) begin
      if (sel_pool) begin
        pool_r <= pwdata[USED_W-1:0];
      end else begin
        base_r <= pwdata[ADDR_W-1:0];
      end
    end
  end

  assign prdata = sel_pool ? CFG_DW'(pool_r) : base_r;
  assign base_o = base_r;
  assign pool_o = pool_r;

endmodule

// ----- hdl/sadf_ctrl.sv -----
module sadf_ctrl
  import sadf_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;
  logic   casc_r, casc_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      casc_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      casc_r  <= casc_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    casc_nxt  = casc_r;
    case (state_r)
      S_IDLE:    if (in_valid) state_nxt = S_DECODE;
      S_DECODE: begin
        case (stat.kind)
          KIND_ALLOC: state_nxt = S_ALIGN;
          KIND_FREE:  state_nxt = stat.faddr_zero ? S_DONE : S_LTEST;
          default:    state_nxt = S_DONE;
        endcase
      end
      S_ALIGN:   state_nxt = S_COMMIT;
      S_COMMIT:  state_nxt = S_DONE;
      S_LTEST:   state_nxt = stat.lidx_zero ? S_DONE : S_LRD;
      S_LRD:     state_nxt = S_LCMP;
      S_LCMP: begin
        if (stat.live_hit && stat.hit_top) begin
          state_nxt = S_POP;
        end else if (stat.live_hit) begin
          state_nxt = S_PTEST;
          casc_nxt  = 1'b0;
        end else begin
          state_nxt = S_LTEST;
        end
      end
      S_POP:     state_nxt = S_CHK;
      S_CHK:     state_nxt = stat.lcount_zero ? S_DONE : S_CHKDATA;
      S_CHKDATA: begin
        state_nxt = S_PTEST;
        casc_nxt  = 1'b1;
      end
      S_PTEST: begin
        if (!stat.pidx_end) begin
          state_nxt = S_PRD;
        end else if (casc_r || stat.pend_full) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_PUSH;
        end
      end
      S_PRD:     state_nxt = S_PCMP;
      S_PCMP: begin
        if (!stat.pend_hit) begin
          state_nxt = S_PTEST;
        end else begin
          state_nxt = casc_r ? S_DROPRD : S_DONE;
        end
      end
      S_DROPRD:  state_nxt = S_DROPWR;
      S_DROPWR:  state_nxt = S_POP;
      S_PUSH:    state_nxt = S_DONE;
      S_DONE:    if (stat.out_free) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    cmd.st   = ST_OK;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      S_DECODE: begin
        case (stat.kind)
          KIND_ALLOC: cmd.alloc_prep = 1'b1;
          KIND_FREE:  cmd.lscan_init = 1'b1;
          KIND_CLEAR: cmd.clear      = 1'b1;
          default: begin
            cmd.set_st = 1'b1;
            cmd.st     = ST_INVALID;
          end
        endcase
      end
      S_ALIGN:   cmd.alloc_prep   = 1'b1;
      S_COMMIT:  cmd.alloc_commit = 1'b1;
      S_LTEST: begin
        if (stat.lidx_zero) begin
          cmd.set_st = 1'b1;
          cmd.st     = ST_INVALID;
        end
      end
      S_LRD:     cmd.live_rd_idx = 1'b1;
      S_LCMP: begin
        if (!stat.live_hit) begin
          cmd.lidx_dec = 1'b1;
        end else if (!stat.hit_top) begin
          cmd.tgt_in = 1'b1;
        end
      end
      S_POP:     cmd.pop = 1'b1;
      S_CHK:     cmd.live_rd_top = !stat.lcount_zero;
      S_CHKDATA: cmd.tgt_live = 1'b1;
      S_PTEST: begin
        if (stat.pidx_end && !casc_r && stat.pend_full) begin
          cmd.set_st = 1'b1;
          cmd.st     = ST_BOOK_FULL;
        end
      end
      S_PRD:     cmd.pend_rd_idx = 1'b1;
      S_PCMP: begin
        if (!stat.pend_hit) begin
          cmd.pidx_inc = 1'b1;
        end else if (!casc_r) begin
          cmd.set_st = 1'b1;
          cmd.st     = ST_INVALID;
        end
      end
      S_DROPRD:  cmd.pend_rd_last = 1'b1;
      S_DROPWR:  cmd.drop_wr = 1'b1;
      S_PUSH:    cmd.push = 1'b1;
      S_DONE:    cmd.emit = stat.out_free;
      default:   cmd = '0;
    endcase
  end

endmodule

// ----- hdl/sadf_dp.sv -----
module sadf_dp
  import sadf_pkg::*;
#(
  parameter int MAX_LIVE     = DEF_MAX_LIVE,
  parameter int MAX_PENDING  = DEF_MAX_PENDING,
  parameter int HEADER_BYTES = DEF_HEADER_BYTES
)(
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  output stat_t             stat,
  input  logic [63:0]       in_tdata,
  input  logic [1:0]        in_tuser,
  input  logic [ADDR_W-1:0] base,
  input  logic [USED_W-1:0] pool,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [63:0]       out_tdata
);

  localparam int LCW = $clog2(MAX_LIVE + 1);
  localparam int LAW = (MAX_LIVE > 1) ? $clog2(MAX_LIVE) : 1;
  localparam int PCW = $clog2(MAX_PENDING + 1);
  localparam int PAW = (MAX_PENDING > 1) ? $clog2(MAX_PENDING) : 1;
  localparam logic [ALIGN_W-1:0] HB = ALIGN_W'(HEADER_BYTES);

  // captured item
  logic [1:0]         kind_r;
  logic [SIZE_W-1:0]  size_r;
  logic [ALIGN_W-1:0] align_r;
  logic [ADDR_W-1:0]  faddr_r;

  // allocator state
  logic [USED_W-1:0] used_r, used_nxt;
  logic [LCW-1:0]    lcount_r, lcount_nxt;
  logic [PCW-1:0]    pcount_r, pcount_nxt;

  // scan working registers
  logic [LCW-1:0]    lidx_r;
  logic [PCW-1:0]    pidx_r;
  logic [ADDR_W-1:0] tgt_r;
  logic [ADDR_W-1:0] top_r;
  logic [ADJ_W-1:0]  adj_r;

  // result
  status_t           res_st_r;
  logic [ADDR_W-1:0] res_addr_r;
  logic              out_valid_r;
  logic [63:0]       out_data_r;

  // memories
  logic [ADDR_W-1:0] live_addr_mem  [MAX_LIVE];
  logic [USED_W-1:0] live_start_mem [MAX_LIVE];
  logic [ADDR_W-1:0] pend_mem       [MAX_PENDING];
  logic [ADDR_W-1:0] live_addr_q;
  logic [USED_W-1:0] live_start_q;
  logic [ADDR_W-1:0] pend_q;

  // alignment
  logic [ADDR_W-1:0]  top_c;
  logic [ALIGN_W-1:0] mask_c, adj0_c, need_c;
  logic [ADJ_W-1:0]   adj_c;

  always_comb begin
    top_c  = base + ADDR_W'(used_r);
    mask_c = align_r - 8'd1;
    adj0_c = (align_r - (top_c[ALIGN_W-1:0] & mask_c)) & mask_c;
    need_c = HB - adj0_c;
    adj_c  = ADJ_W'(adj0_c);
    if (adj0_c < HB) begin
      adj_c = ADJ_W'(adj0_c) + ADJ_W'((need_c + mask_c) & ~mask_c);
    end
  end

  // allocate checks
  logic [TOTAL_W-1:0] total_c;
  logic [ADDR_W-1:0]  new_addr_c;
  logic               bad_req_c;
  status_t            alloc_st_c;
  logic               alloc_ok_c;

  always_comb begin
    total_c    = TOTAL_W'(used_r) + TOTAL_W'(size_r) + TOTAL_W'(adj_r);
    new_addr_c = top_r + ADDR_W'(adj_r);
    bad_req_c  = (size_r == '0) || (align_r == '0) ||
                 ((align_r & (align_r - 8'd1)) != '0);
    if (bad_req_c) begin
      alloc_st_c = ST_INVALID;
    end else if (lcount_r >= LCW'(MAX_LIVE)) begin
      alloc_st_c = ST_BOOK_FULL;
    end else if (total_c > TOTAL_W'(pool)) begin
      alloc_st_c = ST_POOL_FULL;
    end else begin
      alloc_st_c = ST_OK;
    end
    alloc_ok_c = cmd.alloc_commit && (alloc_st_c == ST_OK);
  end

  // counters
  always_comb begin
    used_nxt   = used_r;
    lcount_nxt = lcount_r;
    pcount_nxt = pcount_r;
    if (cmd.clear) begin
      used_nxt   = '0;
      lcount_nxt = '0;
      pcount_nxt = '0;
    end
    if (alloc_ok_c) begin
      used_nxt   = total_c[USED_W-1:0];
      lcount_nxt = lcount_r + 1'b1;
    end
    if (cmd.pop) begin
      used_nxt   = live_start_q;
      lcount_nxt = lcount_r - 1'b1;
    end
    if (cmd.push) pcount_nxt = pcount_r + 1'b1;
    if (cmd.drop_wr) pcount_nxt = pcount_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      lcount_r    <= '0;
      pcount_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      used_r   <= used_nxt;
      lcount_r <= lcount_nxt;
      pcount_r <= pcount_nxt;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      kind_r     <= in_tuser;
      size_r     <= in_tdata[23:0];
      align_r    <= in_tdata[31:24];
      faddr_r    <= in_tdata[63:32];
      res_st_r   <= ST_OK;
      res_addr_r <= '0;
    end
    if (cmd.set_st) res_st_r <= cmd.st;
    if (cmd.alloc_commit) begin
      res_st_r   <= alloc_st_c;
      res_addr_r <= (alloc_st_c == ST_OK) ? new_addr_c : '0;
    end
    if (cmd.alloc_prep) begin
      top_r <= top_c;
      adj_r <= adj_c;
    end
    if (cmd.lscan_init) lidx_r <= lcount_r;
    if (cmd.lidx_dec) lidx_r <= lidx_r - 1'b1;
    if (cmd.tgt_in) begin
      tgt_r  <= faddr_r;
      pidx_r <= '0;
    end
    if (cmd.tgt_live) begin
      tgt_r  <= live_addr_q;
      pidx_r <= '0;
    end
    if (cmd.pidx_inc) pidx_r <= pidx_r + 1'b1;
    if (cmd.emit) begin
      out_data_r <= {LIVEO_W'(lcount_r), used_r, res_st_r, res_addr_r};
    end
  end

  // live list: one write port, one registered read port
  logic [LCW-1:0] lidx_m1;
  logic [LCW-1:0] lcount_m1;
  logic [LAW-1:0] live_raddr;

  assign lidx_m1    = lidx_r - 1'b1;
  assign lcount_m1  = lcount_r - 1'b1;
  assign live_raddr = cmd.live_rd_top ? lcount_m1[LAW-1:0] : lidx_m1[LAW-1:0];

  always_ff @(posedge clk) begin
    if (alloc_ok_c) begin
      live_addr_mem[lcount_r[LAW-1:0]]  <= new_addr_c;
      live_start_mem[lcount_r[LAW-1:0]] <= used_r;
    end
    if (cmd.live_rd_idx || cmd.live_rd_top) begin
      live_addr_q  <= live_addr_mem[live_raddr];
      live_start_q <= live_start_mem[live_raddr];
    end
  end

  // pending list: push at the end, drop moves the last entry into the hole
  logic [PCW-1:0]    pcount_m1;
  logic [PAW-1:0]    pend_raddr;
  logic [PAW-1:0]    pend_waddr;
  logic [ADDR_W-1:0] pend_wdata;

  assign pcount_m1  = pcount_r - 1'b1;
  assign pend_raddr = cmd.pend_rd_last ? pcount_m1[PAW-1:0] : pidx_r[PAW-1:0];
  assign pend_waddr = cmd.push ? pcount_r[PAW-1:0] : pidx_r[PAW-1:0];
  assign pend_wdata = cmd.push ? faddr_r : pend_q;

  always_ff @(posedge clk) begin
    if (cmd.push || cmd.drop_wr) begin
      pend_mem[pend_waddr] <= pend_wdata;
    end
    if (cmd.pend_rd_idx || cmd.pend_rd_last) begin
      pend_q <= pend_mem[pend_raddr];
    end
  end

  // status back to the controller
  always_comb begin
    stat.kind        = kind_t'(kind_r);
    stat.faddr_zero  = faddr_r == '0;
    stat.lidx_zero   = lidx_r == '0;
    stat.live_hit    = live_addr_q == faddr_r;
    stat.hit_top     = lidx_r == lcount_r;
    stat.lcount_zero = lcount_r == '0;
    stat.pidx_end    = pidx_r == pcount_r;
    stat.pend_hit    = pend_q == tgt_r;
    stat.pend_full   = pcount_r >= PCW'(MAX_PENDING);
    stat.out_free    = !out_valid_r || out_tready;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ----- hdl/sadf_checker.sv -----
module sadf_checker
  import sadf_pkg::*;
#(
  parameter int MAX_LIVE = DEF_MAX_LIVE
)(
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata
);

  // a stalled result holds its beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // an address is only handed out by a successful allocate
  a_addr_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[31:0] != '0) |-> out_tdata[33:32] == ST_OK)
    else $error("nonzero block address with failing status");

  // live count never exceeds the stack depth
  a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[63:59] <= MAX_LIVE)
    else $error("live count above stack depth");

  // reset drops any pending result
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind stack_allocator_deferred_free sadf_checker #(
  .MAX_LIVE (MAX_LIVE)
) u_sadf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import sadf_pkg::*;

  // kind code the block does not know; it must answer invalid
  localparam logic [1:0] KIND_UNKNOWN = 2'd3;
  localparam int RAND_PER_SETTING = 105;
  localparam int SETTING_COUNT    = 8;

  // how a free beat finds its address when it is put on the bus
  typedef enum logic [2:0] {
    PICK_FIXED,     // use the address carried in the request
    PICK_TOP,       // newest live block
    PICK_SECOND,    // block just under the newest
    PICK_OLDER,     // any live block below the newest
    PICK_DEFERRED,  // a block already waiting in the deferred list
    PICK_NEAR       // one byte off a live block
  } pick_t;

  typedef struct {
    logic [1:0]  kind;
    logic [23:0] size;
    logic [7:0]  align;
    logic [31:0] faddr;
    pick_t       pick;
    bit          drain;  // hold off until every result is back
  } request_t;

  typedef struct {
    logic [31:0] addr;
    status_t     st;
    logic [24:0] used;
    logic [4:0]  live;
  } outcome_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              in_tvalid = 1'b0;
  wire               in_tready;
  logic [63:0]       in_tdata = '0;   // request_size[23:0], align_bytes[31:24],
                                      // free_address[63:32]
  logic [1:0]        in_tuser = '0;   // kind[1:0]
  wire               out_tvalid;
  logic              out_tready = 1'b0;
  wire  [63:0]       out_tdata;       // block_address[31:0], status[33:32],
                                      // used_after[58:34], live_after[63:59]
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [CFG_DW-1:0] cfg_pwdata = '0;
  wire  [CFG_DW-1:0] cfg_prdata;
  wire               cfg_pready;

  stack_allocator_deferred_free dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------
  // allocator shadow: pool settings, bump pointer, live stack, deferred list
  // ---------------------------------------------------------------------
  logic [31:0] pool_base = '0;
  logic [24:0] pool_limit = POOL_RESET;
  logic [24:0] pool_used = '0;
  logic [31:0] live_addr  [DEF_MAX_LIVE];
  logic [24:0] live_start [DEF_MAX_LIVE];
  int          live_n = 0;
  logic [31:0] defer_addr [DEF_MAX_PENDING];
  int          defer_n = 0;

  // coverage-ish bookkeeping for the closing summary
  int deepest_stack = 0;
  int cascade_pops = 0;
  int beats_sent = 0;
  int beats_checked = 0;
  int status_seen [4] = '{0, 0, 0, 0};
  int n_err = 0;

  request_t request_backlog[$];
  outcome_t results_due[$];

  function automatic int deferred_slot(logic [31:0] a);
    for (int i = 0; i < defer_n; i++)
      if (defer_addr[i] == a) return i;
    return -1;
  endfunction

  // applies one request to the shadow and returns the result beat it owes
  function automatic outcome_t next_pool_result(request_t r);
    outcome_t    o;
    logic [31:0] top, mask, adj, need;
    logic [33:0] total;
    int          hit, p;
    o.addr = '0;
    o.st   = ST_OK;
    case (r.kind)
      KIND_ALLOC: begin
        if (r.size == '0 || r.align == '0 || (r.align & (r.align - 8'd1)) != '0) begin
          o.st = ST_INVALID;
        end else if (live_n >= DEF_MAX_LIVE) begin
          o.st = ST_BOOK_FULL;
        end else begin
          // step to the next multiple of the alignment, keeping header room
          top  = pool_base + 32'(pool_used);
          mask = 32'(r.align) - 32'd1;
          adj  = (32'(r.align) - (top & mask)) & mask;
          if (adj < DEF_HEADER_BYTES) begin
            need = DEF_HEADER_BYTES - adj;
            adj  = adj + ((need + mask) & ~mask);
          end
          total = 34'(pool_used) + 34'(r.size) + 34'(adj);
          if (total > 34'(pool_limit)) begin
            o.st = ST_POOL_FULL;
          end else begin
            live_addr[live_n]  = top + adj;
            live_start[live_n] = pool_used;
            live_n++;
            pool_used = total[24:0];
            o.addr    = top + adj;
            if (live_n > deepest_stack) deepest_stack = live_n;
          end
        end
      end
      KIND_FREE: begin
        if (r.faddr != '0) begin
          hit = -1;
          // newest match wins
          for (int i = live_n - 1; i >= 0; i--) begin
            if (live_addr[i] == r.faddr) begin
              hit = i;
              break;
            end
          end
          if (hit < 0) begin
            o.st = ST_INVALID;
          end else if (hit == live_n - 1) begin
            live_n--;
            pool_used = live_start[live_n];
            // deferred blocks that surface on top go too
            while (live_n > 0) begin
              p = deferred_slot(live_addr[live_n - 1]);
              if (p < 0) break;
              live_n--;
              pool_used = live_start[live_n];
              defer_n--;
              defer_addr[p] = defer_addr[defer_n];
              cascade_pops++;
            end
          end else if (deferred_slot(r.faddr) >= 0) begin
            o.st = ST_INVALID;
          end else if (defer_n >= DEF_MAX_PENDING) begin
            o.st = ST_BOOK_FULL;
          end else begin
            defer_addr[defer_n] = r.faddr;
            defer_n++;
          end
        end
      end
      KIND_CLEAR: begin
        pool_used = '0;
        live_n    = 0;
        defer_n   = 0;
      end
      default: o.st = ST_INVALID;
    endcase
    o.used = pool_used;
    o.live = 5'(live_n);
    return o;
  endfunction

  // free addresses are chosen against the shadow as it stands when the beat
  // goes out, so they hit live blocks; with nothing to pick, the carried one
  function automatic logic [31:0] pick_address(request_t r);
    case (r.pick)
      PICK_TOP:      if (live_n > 0) return live_addr[live_n - 1];
      PICK_SECOND:   if (live_n > 1) return live_addr[live_n - 2];
      PICK_OLDER:    if (live_n > 1) return live_addr[$urandom_range(0, live_n - 2)];
      PICK_DEFERRED: if (defer_n > 0) return defer_addr[$urandom_range(0, defer_n - 1)];
      PICK_NEAR:
        if (live_n > 0)
          return live_addr[$urandom_range(0, live_n - 1)] +
                 ($urandom_range(0, 1) ? 32'd1 : -32'd1);
      default: ;
    endcase
    return r.faddr;
  endfunction

  // mostly short idles, now and then a long one
  function automatic int idle_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom_range(1, 3);
    if (roll < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // mostly well-formed allocate/free traffic so the stack gets deep and
  // deferred frees cascade; the rest is malformed or noise
  function automatic request_t random_request();
    request_t r;
    int       roll;
    roll    = $urandom_range(0, 99);
    r.kind  = KIND_ALLOC;
    r.size  = 24'($urandom_range(1, 64));
    r.align = 8'(1 << $urandom_range(0, 7));
    r.faddr = $urandom | 32'd1;
    r.pick  = PICK_FIXED;
    r.drain = ($urandom_range(0, 99) == 0);
    if (roll < 50) begin
      case ($urandom_range(0, 9))
        0: r.size = 24'($urandom_range(65, 4096));
        1: r.size = 24'($urandom);
        default: ;
      endcase
    end else if (roll < 80) begin
      r.kind = KIND_FREE;
      if (roll < 62)      r.pick = PICK_TOP;
      else if (roll < 72) r.pick = PICK_OLDER;
      else if (roll < 75) r.pick = PICK_SECOND;
      else if (roll < 78) r.pick = PICK_DEFERRED;
      else                r.pick = PICK_NEAR;
    end else if (roll < 85) begin
      r.kind = KIND_FREE;
      if (roll < 82) r.faddr = '0;
    end else if (roll < 87) begin
      r.kind = KIND_CLEAR;
    end else if (roll < 94) begin
      // any alignment byte, sometimes a zero size
      r.align = 8'($urandom);
      r.size  = (roll < 89) ? 24'd0 : 24'($urandom);
    end else if (roll < 96) begin
      r.kind  = KIND_UNKNOWN;
      r.size  = 24'($urandom);
      r.align = 8'($urandom);
    end
    return r;
  endfunction

  task automatic queue_request(input logic [1:0] k, input logic [23:0] sz,
                               input logic [7:0] al, input logic [31:0] fa,
                               input pick_t pk);
    request_t r;
    r.kind  = k;
    r.size  = sz;
    r.align = al;
    r.faddr = fa;
    r.pick  = pk;
    r.drain = 1'b0;
    request_backlog = {request_backlog, r};
  endtask

  // apb write: setup then access; lands on the edge with penable high
  task automatic apb_write(input logic [CFG_AW-1:0] a, input logic [31:0] d);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= a;
    cfg_pwdata  <= d;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic program_pool(input logic [31:0] b, input logic [24:0] s);
    apb_write(REG_BASE_ADDR, b);
    apb_write(REG_POOL_ADDR, 32'(s));
    pool_base  = b;
    pool_limit = s;
  endtask

  // block is idle: nothing queued, nothing on the bus, every result back
  task automatic wait_idle();
    do @(negedge clk);
    while (request_backlog.size() != 0 || in_tvalid || results_due.size() != 0);
    repeat (10) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------
  // request driver
  // ---------------------------------------------------------------------
  request_t cur_req;
  int       tx_gap = 0;
  int       tx_calm = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      // beat taken on this edge: shadow moves on and owes one result
      if (in_tvalid && in_tready) begin
        results_due = {results_due, next_pool_result(cur_req)};
        beats_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_tvalid <= 1'b0;
        end else if (request_backlog.size() != 0 &&
                     !(request_backlog[0].drain && results_due.size() != 0)) begin
          cur_req = request_backlog.pop_front();
          cur_req.faddr = pick_address(cur_req);
          in_tvalid <= 1'b1;
          in_tdata  <= {cur_req.faddr, cur_req.align, cur_req.size};
          in_tuser  <= cur_req.kind;
          // idle before the following beat; calm stretches send back to back
          if (tx_calm > 0) begin
            tx_calm--;
            tx_gap = 0;
          end else if ($urandom_range(0, 49) == 0) begin
            tx_calm = $urandom_range(20, 60);
            tx_gap  = 0;
          end else begin
            tx_gap = $urandom_range(0, 1) ? 0 : idle_len();
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // result monitor and checker
  // ---------------------------------------------------------------------
  wire [31:0] res_addr   = out_tdata[31:0];
  wire [1:0]  res_status = out_tdata[33:32];
  wire [24:0] res_used   = out_tdata[58:34];
  wire [4:0]  res_live   = out_tdata[63:59];

  outcome_t want;
  int       rx_wait = 0;
  int       rx_calm = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (results_due.size() == 0) begin
          $display("%0t ns: result beat with none expected, tdata %h", $time, out_tdata);
          n_err++;
        end else begin
          want = results_due.pop_front();
          beats_checked++;
          status_seen[res_status]++;
          if (res_addr !== want.addr) begin
            $display("%0t ns: block_address expected %h got %h", $time, want.addr, res_addr);
            n_err++;
          end
          if (res_status !== want.st) begin
            $display("%0t ns: status expected %0d got %0d", $time, want.st, res_status);
            n_err++;
          end
          if (res_used !== want.used) begin
            $display("%0t ns: used_after expected %0d got %0d", $time, want.used, res_used);
            n_err++;
          end
          if (res_live !== want.live) begin
            $display("%0t ns: live_after expected %0d got %0d", $time, want.live, res_live);
            n_err++;
          end
        end
      end
      // back-pressure: random stalls, with calm stretches of none
      if (rx_wait > 0) begin
        rx_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (rx_calm > 0)
          rx_calm--;
        else if ($urandom_range(0, 49) == 0)
          rx_calm = $urandom_range(30, 80);
        else if ($urandom_range(0, 3) == 0)
          rx_wait = idle_len();
      end
    end
  end

  // ---------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------
  initial begin
    request_t    r;
    logic [31:0] b;
    logic [24:0] s;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed part under the reset pool settings
    queue_request(KIND_ALLOC, 24'd0, 8'd4, 32'd0, PICK_FIXED);       // zero size
    queue_request(KIND_ALLOC, 24'd8, 8'd0, 32'd0, PICK_FIXED);       // zero alignment
    queue_request(KIND_ALLOC, 24'd8, 8'd3, 32'd0, PICK_FIXED);       // not a power of two
    queue_request(KIND_ALLOC, 24'd8, 8'hFF, 32'd0, PICK_FIXED);
    queue_request(KIND_UNKNOWN, 24'hFFFFFF, 8'hFF, 32'hFFFF_FFFF, PICK_FIXED);
    queue_request(KIND_FREE, 24'd0, 8'd0, 32'd0, PICK_FIXED);        // null free
    queue_request(KIND_FREE, 24'd0, 8'd0, 32'hDEAD_BEEF, PICK_FIXED); // unknown address
    queue_request(KIND_ALLOC, 24'd16, 8'd1, 32'd0, PICK_FIXED);
    queue_request(KIND_ALLOC, 24'd1, 8'd128, 32'd0, PICK_FIXED);
    queue_request(KIND_ALLOC, 24'd100, 8'd8, 32'd0, PICK_FIXED);
    queue_request(KIND_ALLOC, 24'd5, 8'd2, 32'd0, PICK_FIXED);
    queue_request(KIND_ALLOC, 24'd7, 8'd64, 32'd0, PICK_FIXED);
    queue_request(KIND_ALLOC, 24'hFFFFFF, 8'd16, 32'd0, PICK_FIXED); // pool exhausted
    queue_request(KIND_FREE, 24'd0, 8'd0, 32'h1, PICK_SECOND);       // deferred
    queue_request(KIND_FREE, 24'd0, 8'd0, 32'h1, PICK_DEFERRED);     // deferred twice
    queue_request(KIND_FREE, 24'd0, 8'd0, 32'h1, PICK_NEAR);         // near miss
    queue_request(KIND_FREE, 24'd0, 8'd0, 32'h1, PICK_OLDER);
    queue_request(KIND_FREE, 24'd0, 8'd0, 32'h1, PICK_TOP);          // pops, then cascades
    queue_request(KIND_FREE, 24'd0, 8'd0, 32'h1, PICK_TOP);
    queue_request(KIND_CLEAR, 24'hABCDEF, 8'h5A, 32'h1234_5678, PICK_FIXED);
    queue_request(KIND_FREE, 24'd0, 8'd0, 32'h8000_0001, PICK_TOP);  // empty stack
    queue_request(KIND_ALLOC, 24'd1, 8'd4, 32'd0, PICK_FIXED);

    for (int ph = 0; ph < SETTING_COUNT; ph++) begin
      case (ph)
        0:       begin b = 32'd0;          s = 25'h100_0000;  end
        1:       begin b = 32'hFFFF_FFFF;  s = 25'd4096;      end
        2:       begin b = $urandom;       s = 25'd0;         end
        3:       begin b = $urandom;       s = 25'd300;       end
        4:       begin b = 32'h0000_0003;  s = 25'd2048;      end
        5:       begin b = 32'hFFFF_FF80;  s = 25'd1024;      end
        6:       begin b = $urandom;       s = 25'($urandom_range(1, 1 << 20)); end
        default: begin b = $urandom;       s = POOL_RESET;    end
      endcase
      wait_idle();
      program_pool(b, s);
      if (ph == 0) begin
        // largest pool: exact fit, then one byte over
        queue_request(KIND_CLEAR, 24'd0, 8'd0, 32'd0, PICK_FIXED);
        queue_request(KIND_ALLOC, 24'hFFFFFC, 8'd1, 32'd0, PICK_FIXED);
        queue_request(KIND_ALLOC, 24'd1, 8'd1, 32'd0, PICK_FIXED);
        queue_request(KIND_FREE, 24'd0, 8'd0, 32'h1, PICK_TOP);
        queue_request(KIND_ALLOC, 24'hFFFFFF, 8'd128, 32'd0, PICK_FIXED);
      end
      for (int k = 0; k < RAND_PER_SETTING; k++) begin
        r = random_request();
        if (k == RAND_PER_SETTING / 2) r.drain = 1'b1;
        request_backlog = {request_backlog, r};
      end
    end

    wait_idle();
    repeat (20) @(posedge clk);
    $display("covered %0d requests over %0d pool settings: %0d ok, %0d exhausted, %0d full, %0d invalid",
             beats_sent, SETTING_COUNT + 1, status_seen[0], status_seen[1],
             status_seen[2], status_seen[3]);
    $display("deepest live stack %0d, deferred pops %0d, %0d results checked, %0d mismatches",
             deepest_stack, cascade_pops, beats_checked, n_err);
    if (n_err == 0 && results_due.size() == 0)
      $display("PASS stack_allocator_deferred_free");
    else
      $display("FAIL stack_allocator_deferred_free");
    $finish;
  end

  // hard stop well past the slowest legal run
  initial begin
    #200_000_000;
    $display("timeout with %0d results outstanding", results_due.size());
    $display("FAIL stack_allocator_deferred_free");
    $finish;
  end

endmodule

// ----- stack_allocator_deferred_free.f -----
hdl/sadf_pkg.sv
hdl/sadf_regs.sv
hdl/sadf_ctrl.sv
hdl/sadf_dp.sv
hdl/stack_allocator_deferred_free.sv
hdl/sadf_checker.sv
verif/tb_top.sv
